// File: design/bdsl_pkg.sv
// ----------------------------------------------------------------------------
// bdsl_pkg
// Shared types and constants of the BCD display scanner with decimal load.
// ----------------------------------------------------------------------------
package bdsl_pkg;

  // Default digit count of the store.
  localparam int DIGITS_DEFAULT = 6;

  // Fixed field widths.
  localparam int CMD_W   = 2;
  localparam int VALUE_W = 32;
  localparam int HALF_W  = 16;
  localparam int BCD_W   = 4;
  localparam int POS_W   = 3;

  // Command codes on the input channel.
  localparam logic [CMD_W-1:0] CMD_TICK       = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD_FULL  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_LOAD_RED   = 2'd2;
  localparam logic [CMD_W-1:0] CMD_LOAD_GREEN = 2'd3;

  // Classified operation as it travels through the queue.
  typedef enum logic [1:0] {
    OP_TICK,
    OP_LOAD_FULL,
    OP_LOAD_RED,
    OP_LOAD_GREEN
  } op_t;

  // One queued item.
  typedef struct packed {
    op_t                op;
    logic [VALUE_W-1:0] value;
  } q_item_t;

  // Write side of the queue.
  typedef struct packed {
    logic    valid;
    q_item_t item;
  } q_push_t;

  // Read side of the queue.
  typedef struct packed {
    logic    valid;
    q_item_t item;
  } q_head_t;

  // Back-end sequencer states.
  typedef enum logic {
    ST_IDLE,
    ST_CONV
  } state_t;

endpackage

// File: design/bcd_display_scan_with_decimal_load.sv
// ----------------------------------------------------------------------------
// bcd_display_scan_with_decimal_load
// Multiplexed BCD display scanner with a binary-to-decimal load path.
// ----------------------------------------------------------------------------
// Usage:
//   The command channel (cmd_valid / cmd_stall) takes one item per command:
//   a tick, a full load, or a half load into the red or green half. The
//   display channel (disp_valid / disp_stall) returns one item per tick with
//   the BCD code, the counter reset and clock pulses, and the store entry.
//   Loads return nothing.
//   Items pass through a two-entry queue into the executing back end. A tick
//   shows its result on the display ports through the output register once
//   the back end takes it from the queue, and the back end takes one tick per
//   cycle while the receiver does not stall. A load occupies the back end for
//   a fetch of the item and 32 double-dabble steps, one value bit per cycle,
//   set by the single shared BCD shift-and-correct unit. Items queued behind
//   a load wait for it, so a load followed by a tick shows the new digits.
//   Reset clears the digit store, the scan position and the queue.
//   While the receiver stalls, the held result stays stable, the next tick
//   waits in the queue, and the command channel stalls once the queue fills.
// ----------------------------------------------------------------------------
module bcd_display_scan_with_decimal_load #(
  parameter int DIGITS = bdsl_pkg::DIGITS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cmd_valid,
  output logic                          cmd_stall,
  input  logic [bdsl_pkg::CMD_W-1:0]    command,
  input  logic [bdsl_pkg::VALUE_W-1:0]  value,
  output logic                          disp_valid,
  input  logic                          disp_stall,
  output logic [bdsl_pkg::BCD_W-1:0]    bcd_code,
  output logic                          reset_pulse,
  output logic                          clock_pulse,
  output logic [bdsl_pkg::POS_W-1:0]    position
);

  bdsl_pkg::q_push_t push;
  bdsl_pkg::q_head_t head;
  logic              q_full;
  logic              pop;

  // Front end: accept and classify.
  bdsl_front u_front (
    .cmd_valid (cmd_valid),
    .command   (command),
    .value     (value),
    .q_full    (q_full),
    .cmd_stall (cmd_stall),
    .push      (push)
  );

  // Queue between front and back.
  bdsl_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .pop  (pop),
    .full (q_full),
    .head (head)
  );

  // Back end: scan and convert.
  bdsl_back #(
    .DIGITS (DIGITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .pop         (pop),
    .disp_valid  (disp_valid),
    .disp_stall  (disp_stall),
    .bcd_code    (bcd_code),
    .reset_pulse (reset_pulse),
    .clock_pulse (clock_pulse),
    .position    (position)
  );

endmodule

// File: design/bdsl_front.sv
// ----------------------------------------------------------------------------
// bdsl_front
// Accepts command items, classifies them and masks half-load values.
// ----------------------------------------------------------------------------
module bdsl_front (
  input  logic                          cmd_valid,
  input  logic [bdsl_pkg::CMD_W-1:0]    command,
  input  logic [bdsl_pkg::VALUE_W-1:0]  value,
  input  logic                          q_full,
  output logic                          cmd_stall,
  output bdsl_pkg::q_push_t             push
);

  // The front only stalls when the queue has no room.
  assign cmd_stall = q_full;

  // Decode the command and trim the value for half loads.
  always_comb begin
    push.valid      = cmd_valid && !q_full;
    push.item.value = value;
    unique case (command)
      bdsl_pkg::CMD_TICK: begin
        push.item.op = bdsl_pkg::OP_TICK;
      end
      bdsl_pkg::CMD_LOAD_FULL: begin
        push.item.op = bdsl_pkg::OP_LOAD_FULL;
      end
      bdsl_pkg::CMD_LOAD_RED: begin
        push.item.op    = bdsl_pkg::OP_LOAD_RED;
        push.item.value = {{(bdsl_pkg::VALUE_W-bdsl_pkg::HALF_W){1'b0}},
                           value[bdsl_pkg::HALF_W-1:0]};
      end
      default: begin
        push.item.op    = bdsl_pkg::OP_LOAD_GREEN;
        push.item.value = {{(bdsl_pkg::VALUE_W-bdsl_pkg::HALF_W){1'b0}},
                           value[bdsl_pkg::HALF_W-1:0]};
      end
    endcase
  end

endmodule

// File: design/bdsl_queue.sv
// ----------------------------------------------------------------------------
// bdsl_queue
// Two-entry queue between the front and the back of the scanner.
// ----------------------------------------------------------------------------
module bdsl_queue (
  input  logic              clk,
  input  logic              rst,
  input  bdsl_pkg::q_push_t push,
  input  logic              pop,
  output logic              full,
  output bdsl_pkg::q_head_t head
);

  bdsl_pkg::q_item_t slots [2];
  logic              wr_ptr;
  logic              rd_ptr;
  logic [1:0]        count;

  assign full       = (count == 2'd2);
  assign head.valid = (count != 2'd0);
  assign head.item  = slots[rd_ptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push.valid) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push.valid && !pop) begin
        count <= count + 2'd1;
      end else if (!push.valid && pop) begin
        count <= count - 2'd1;
      end
    end
  end

  // Slot storage.
  always_ff @(posedge clk) begin
    if (push.valid) begin
      slots[wr_ptr] <= push.item;
    end
  end

endmodule

// File: design/bdsl_back.sv
// ----------------------------------------------------------------------------
// bdsl_back
// Executes queued items: scan ticks and bit-serial decimal loads.
// ----------------------------------------------------------------------------
module bdsl_back #(
  parameter int DIGITS = bdsl_pkg::DIGITS_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  bdsl_pkg::q_head_t            head,
  output logic                         pop,
  output logic                         disp_valid,
  input  logic                         disp_stall,
  output logic [bdsl_pkg::BCD_W-1:0]   bcd_code,
  output logic                         reset_pulse,
  output logic                         clock_pulse,
  output logic [bdsl_pkg::POS_W-1:0]   position
);

  localparam int HALF   = DIGITS / 2;
  localparam int IDX_W  = $clog2(DIGITS);
  localparam int SCAN_W = $clog2(DIGITS + 1);
  localparam int DW     = bdsl_pkg::BCD_W * DIGITS;
  localparam int CNT_W  = $clog2(bdsl_pkg::VALUE_W);
  localparam logic [CNT_W-1:0]  CNT_LAST  = CNT_W'(bdsl_pkg::VALUE_W - 1);
  localparam logic [SCAN_W-1:0] SCAN_TOP  = SCAN_W'(DIGITS);
  localparam logic [IDX_W-1:0]  ENTRY_TOP = IDX_W'(DIGITS - 1);

  bdsl_pkg::state_t         state;
  bdsl_pkg::state_t         state_next;
  logic [bdsl_pkg::BCD_W-1:0] digit_store [DIGITS];
  logic [SCAN_W-1:0]        scan_index;
  logic [SCAN_W-1:0]        scan_index_next;
  logic [CNT_W-1:0]         bit_cnt;
  logic [bdsl_pkg::VALUE_W-1:0] bin;
  logic [DW-1:0]            bcd;
  logic [DW-1:0]            bcd_adj;
  logic [DW-1:0]            bcd_next;
  bdsl_pkg::op_t            load_op;
  logic                     out_free;
  logic                     tick_fire;
  logic                     load_start;
  logic                     conv_step;
  logic                     conv_done;
  logic                     wrap;
  logic [SCAN_W-1:0]        scan_eff;
  logic [IDX_W-1:0]         entry;
  logic [DIGITS-1:0]        wr_mask;
  logic [bdsl_pkg::BCD_W-1:0] wr_digit [DIGITS];

  assign out_free = !disp_valid || !disp_stall;

  // Next state of the sequencer.
  always_comb begin
    state_next = state;
    unique case (state)
      bdsl_pkg::ST_IDLE: begin
        if (head.valid && head.item.op != bdsl_pkg::OP_TICK) begin
          state_next = bdsl_pkg::ST_CONV;
        end
      end
      default: begin
        if (bit_cnt == CNT_LAST) begin
          state_next = bdsl_pkg::ST_IDLE;
        end
      end
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    pop        = 1'b0;
    tick_fire  = 1'b0;
    load_start = 1'b0;
    conv_step  = 1'b0;
    conv_done  = 1'b0;
    unique case (state)
      bdsl_pkg::ST_IDLE: begin
        if (head.valid) begin
          if (head.item.op == bdsl_pkg::OP_TICK) begin
            if (out_free) begin
              pop       = 1'b1;
              tick_fire = 1'b1;
            end
          end else begin
            pop        = 1'b1;
            load_start = 1'b1;
          end
        end
      end
      default: begin
        conv_step = 1'b1;
        conv_done = (bit_cnt == CNT_LAST);
      end
    endcase
  end

  // Scan position: wrap once the position has run past the last entry.
  always_comb begin
    wrap            = (scan_index >= SCAN_TOP);
    scan_eff        = wrap ? '0 : scan_index;
    entry           = ENTRY_TOP - scan_eff[IDX_W-1:0];
    scan_index_next = scan_eff + SCAN_W'(1);
  end

  // One double-dabble step: add three to every digit of five or more, then shift.
  always_comb begin
    for (int k = 0; k < DIGITS; k++) begin
      if (bcd[bdsl_pkg::BCD_W*k +: bdsl_pkg::BCD_W] >= 4'd5) begin
        bcd_adj[bdsl_pkg::BCD_W*k +: bdsl_pkg::BCD_W] =
          bcd[bdsl_pkg::BCD_W*k +: bdsl_pkg::BCD_W] + 4'd3;
      end else begin
        bcd_adj[bdsl_pkg::BCD_W*k +: bdsl_pkg::BCD_W] =
          bcd[bdsl_pkg::BCD_W*k +: bdsl_pkg::BCD_W];
      end
    end
    bcd_next = {bcd_adj[DW-2:0], bin[bdsl_pkg::VALUE_W-1]};
  end

  // Which store entries a finished load writes, and with which digit.
  always_comb begin
    for (int k = 0; k < DIGITS; k++) begin
      int src;
      src = k;
      unique case (load_op)
        bdsl_pkg::OP_LOAD_FULL: begin
          wr_mask[k] = 1'b1;
        end
        bdsl_pkg::OP_LOAD_RED: begin
          wr_mask[k] = (k < HALF);
        end
        bdsl_pkg::OP_LOAD_GREEN: begin
          wr_mask[k] = (k >= HALF) && (k < 2 * HALF);
          src        = (k >= HALF) ? k - HALF : 0;
        end
        default: begin
          wr_mask[k] = 1'b0;
        end
      endcase
      wr_digit[k] = bcd_next[bdsl_pkg::BCD_W*src +: bdsl_pkg::BCD_W];
    end
  end

  // Control state and the digit store.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= bdsl_pkg::ST_IDLE;
      scan_index <= '0;
      bit_cnt    <= '0;
      disp_valid <= 1'b0;
      for (int k = 0; k < DIGITS; k++) begin
        digit_store[k] <= '0;
      end
    end else begin
      state <= state_next;
      if (tick_fire) begin
        disp_valid <= 1'b1;
        scan_index <= scan_index_next;
      end else if (!disp_stall) begin
        disp_valid <= 1'b0;
      end
      if (load_start) begin
        bit_cnt <= '0;
      end else if (conv_step) begin
        bit_cnt <= bit_cnt + CNT_W'(1);
      end
      if (conv_done) begin
        for (int k = 0; k < DIGITS; k++) begin
          if (wr_mask[k]) begin
            digit_store[k] <= wr_digit[k];
          end
        end
      end
    end
  end

  // Conversion datapath and the output register.
  always_ff @(posedge clk) begin
    if (load_start) begin
      bin     <= head.item.value;
      bcd     <= '0;
      load_op <= head.item.op;
    end else if (conv_step) begin
      bin <= {bin[bdsl_pkg::VALUE_W-2:0], 1'b0};
      bcd <= bcd_next;
    end
    if (tick_fire) begin
      bcd_code    <= digit_store[entry];
      reset_pulse <= wrap;
      clock_pulse <= !wrap;
      position    <= bdsl_pkg::POS_W'(entry);
    end
  end

endmodule
